// File: hw/rtl/dnsg_pkg.sv
package dnsg_pkg;

    localparam int INDEX_W    = 64;
    localparam int BASE_W     = 5;
    localparam int ORDER_W    = 6;
    localparam int COORD_W    = 5;
    localparam int ENTRY_W    = 4;
    localparam int DIG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [BASE_W-1:0]  BASE_MIN    = 5'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX    = 5'd16;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd32;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ORDER = 1'b1;

    typedef logic [BASE_W-1:0] base_t;
    typedef logic [DIG_W-1:0]  digit_t;

    typedef struct packed {
        logic clear;
        logic feed_valid;
        logic feed_bit;
        logic shift;
    } chain_ctrl_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic first_bit;
        logic last_bit;
        logic shift;
    } lane_ctrl_t;

endpackage

// File: hw/rtl/dnsg_ram.sv
module dnsg_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/dnsg_div_chain.sv
module dnsg_div_chain #(
    parameter int CELLS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dnsg_pkg::chain_ctrl_t ctrl,
    input  dnsg_pkg::base_t       base,
    output dnsg_pkg::digit_t      digit
);

    import dnsg_pkg::*;

    digit_t           rem_reg [CELLS];
    logic [CELLS-1:0] link_v_reg;
    logic [CELLS-1:0] link_q_reg;
    logic [CELLS-1:0] quo_bit;

    // valid token walks down the chain next to the quotient bit stream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_v_reg <= '0;
        end else if (ctrl.clear) begin
            link_v_reg <= '0;
        end else begin
            link_v_reg <= CELLS'({link_v_reg, ctrl.feed_valid});
        end
    end

    always_ff @(posedge aclk) begin
        link_q_reg <= CELLS'({quo_bit, ctrl.feed_bit});
    end

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        logic [BASE_W-1:0] trial;
        digit_t            rem_next;
        digit_t            upper;

        // one restoring division step per incoming bit
        assign trial      = {rem_reg[k], link_q_reg[k]};
        assign quo_bit[k] = (trial >= base);
        assign rem_next   = quo_bit[k] ? DIG_W'(trial - base) : trial[DIG_W-1:0];

        if (k < CELLS - 1) begin : g_mid
            assign upper = rem_reg[k+1];
        end else begin : g_end
            assign upper = '0;
        end

        always_ff @(posedge aclk) begin
            if (ctrl.clear) begin
                rem_reg[k] <= '0;
            end else if (ctrl.shift) begin
                rem_reg[k] <= upper;
            end else if (link_v_reg[k]) begin
                rem_reg[k] <= rem_next;
            end
        end
    end

    assign digit = rem_reg[0];

endmodule

// File: hw/rtl/dnsg_row_lanes.sv
module dnsg_row_lanes #(
    parameter int ROWS = 32,
    parameter int DIGIT_BITS = 4,
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                     aclk,
    input  dnsg_pkg::lane_ctrl_t     ctrl,
    input  dnsg_pkg::base_t          base,
    input  dnsg_pkg::digit_t         digit,
    input  logic                     wr_en,
    input  logic [dnsg_pkg::COORD_W-1:0] wr_row,
    input  logic [dnsg_pkg::COORD_W-1:0] wr_col,
    input  logic [DIGIT_BITS-1:0]    wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output dnsg_pkg::digit_t         sum_out
);

    import dnsg_pkg::*;

    logic [BASE_W:0]   base2;
    logic [BASE_W:0]   base1;
    logic [ADDR_W-1:0] wr_addr;
    digit_t            acc_reg [ROWS];

    assign base2   = {base, 1'b0};
    assign base1   = {1'b0, base};
    assign wr_addr = ADDR_W'(wr_col);

    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        logic [DIGIT_BITS-1:0] rd_data;
        logic [DIGIT_BITS-1:0] bits_reg;
        logic [DIGIT_BITS-1:0] bits_cur;
        digit_t                prod_reg;
        logic                  mbit;
        logic [BASE_W:0]       dbl;
        digit_t                prod_next;
        logic [BASE_W-1:0]     acc_sum;
        digit_t                acc_new;
        digit_t                upper;

        dnsg_ram #(
            .WIDTH (DIGIT_BITS),
            .DEPTH (ROWS)
        ) u_ram (
            .clk     (aclk),
            .wr_en   (wr_en && (int'(wr_row) == r)),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_addr (rd_addr),
            .rd_data (rd_data)
        );

        // entry bits msb first, horner form of entry times digit mod base
        assign bits_cur  = ctrl.first_bit ? rd_data : bits_reg;
        assign mbit      = bits_cur[DIGIT_BITS-1];
        assign dbl       = {1'b0, prod_reg, 1'b0} + (mbit ? (BASE_W+1)'(digit) : '0);
        assign prod_next = (dbl >= base2) ? DIG_W'(dbl - base2) :
                           (dbl >= base1) ? DIG_W'(dbl - base1) : dbl[DIG_W-1:0];
        assign acc_sum   = {1'b0, acc_reg[r]} + {1'b0, prod_next};
        assign acc_new   = (acc_sum >= base) ? DIG_W'(acc_sum - base) : acc_sum[DIG_W-1:0];

        if (r < ROWS - 1) begin : g_mid
            assign upper = acc_reg[r+1];
        end else begin : g_end
            assign upper = '0;
        end

        always_ff @(posedge aclk) begin
            if (ctrl.clear) begin
                acc_reg[r] <= '0;
                prod_reg   <= '0;
            end else if (ctrl.shift) begin
                acc_reg[r] <= upper;
            end else if (ctrl.step) begin
                bits_reg <= bits_cur << 1;
                if (ctrl.last_bit) begin
                    acc_reg[r] <= acc_new;
                    prod_reg   <= '0;
                end else begin
                    prod_reg <= prod_next;
                end
            end
        end
    end

    assign sum_out = acc_reg[0];

endmodule

// File: hw/rtl/digital_net_sample_generator_core.sv
// Digital net sample generator in base b (2 to 16). A load item (action 0)
// writes one generator matrix digit and gives no result. A compute item
// (action 1) gives one sample: the index is split into base-b digits by a
// chain of MAX_ORDER remainder cells fed one index bit per cycle, the matrix
// is then applied one column at a time over m columns, each row lane
// multiplying its entry bit-serially, and the row digits are packed by
// Horner steps, with m = min(matrix_order, MAX_ORDER).
// The matrix is held in one RAM per row and is not cleared at reset: entries
// must be loaded before a compute item uses them.
module digital_net_sample_generator_core #(
    parameter int MAX_ORDER  = 32,
    parameter int DIGIT_BITS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dnsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dnsg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [dnsg_pkg::COORD_W-1:0]        s_entry_row,
    input  logic [dnsg_pkg::COORD_W-1:0]        s_entry_col,
    input  logic [dnsg_pkg::ENTRY_W-1:0]        s_entry_digit,
    input  logic [dnsg_pkg::INDEX_W-1:0]        s_sample_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dnsg_pkg::INDEX_W-1:0]        m_sample_value
);

    import dnsg_pkg::*;

    localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W  = $clog2(MAX_ORDER + INDEX_W);
    localparam int COL_W  = $clog2(MAX_ORDER + 1);
    localparam int BIT_W  = (DIGIT_BITS > 1) ? $clog2(DIGIT_BITS) : 1;

    localparam logic [CNT_W-1:0] EXT_LAST  = CNT_W'(MAX_ORDER + INDEX_W - 1);
    localparam logic [CNT_W-1:0] FEED_LEN  = CNT_W'(INDEX_W);
    localparam logic [BIT_W-1:0] BIT_LAST  = BIT_W'(DIGIT_BITS - 1);
    localparam logic [COL_W-1:0] ORDER_CAP = COL_W'(MAX_ORDER);
    localparam logic [COL_W-1:0] COL_ONE   = COL_W'(1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXT  = 3'd1;
    localparam logic [2:0] ST_MAT  = 3'd2;
    localparam logic [2:0] ST_PACK = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [INDEX_W-1:0] result_reg, result_next;
    logic               m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0] m_data_reg, m_data_next;
    base_t              base_reg;
    logic [ORDER_W-1:0] order_reg;

    base_t              base_eff;
    logic [COL_W-1:0]   order_eff;
    logic               in_acc;
    logic               load_ok;
    logic [COL_W-1:0]   rd_col;
    chain_ctrl_t        chain_ctrl;
    lane_ctrl_t         lane_ctrl;
    digit_t             digit;
    digit_t             lane_sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_MIN;
            order_reg <= ORDER_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIGIT_BASE:   base_reg  <= cfg_wdata[BASE_W-1:0];
                REG_MATRIX_ORDER: order_reg <= cfg_wdata[ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (base_reg < BASE_MIN) begin
            base_eff = BASE_MIN;
        end else if (base_reg > BASE_MAX) begin
            base_eff = BASE_MAX;
        end else begin
            base_eff = base_reg;
        end
        if (int'(order_reg) > MAX_ORDER) begin
            order_eff = ORDER_CAP;
        end else begin
            order_eff = COL_W'(order_reg);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign load_ok = in_acc && (s_action == ACT_LOAD) &&
                     (int'(s_entry_row) < MAX_ORDER) && (int'(s_entry_col) < MAX_ORDER);

    // next column address goes out during the last bit of the current column so its registered read data is ready
    assign rd_col = ((state_reg == ST_MAT) && lane_ctrl.last_bit) ? col_reg + COL_ONE : col_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        col_next     = col_reg;
        bit_next     = bit_reg;
        index_next   = index_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        chain_ctrl            = '0;
        chain_ctrl.feed_bit   = index_reg[INDEX_W-1];
        chain_ctrl.feed_valid = (state_reg == ST_EXT) && (cnt_reg < FEED_LEN);
        lane_ctrl             = '0;
        lane_ctrl.first_bit   = (bit_reg == '0);
        lane_ctrl.last_bit    = (bit_reg == BIT_LAST);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_action == ACT_COMPUTE)) begin
                    index_next       = s_sample_index;
                    cnt_next         = '0;
                    col_next         = '0;
                    chain_ctrl.clear = 1'b1;
                    state_next       = ST_EXT;
                end
            end
            ST_EXT: begin
                index_next = index_reg << 1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == EXT_LAST) begin
                    bit_next        = '0;
                    col_next        = '0;
                    result_next     = '0;
                    lane_ctrl.clear = 1'b1;
                    state_next      = (order_eff == '0) ? ST_OUT : ST_MAT;
                end
            end
            ST_MAT: begin
                lane_ctrl.step = 1'b1;
                if (lane_ctrl.last_bit) begin
                    bit_next         = '0;
                    chain_ctrl.shift = 1'b1;
                    if (col_reg == order_eff - COL_ONE) begin
                        col_next   = '0;
                        state_next = ST_PACK;
                    end else begin
                        col_next = col_reg + COL_ONE;
                    end
                end else begin
                    bit_next = bit_reg + BIT_W'(1);
                end
            end
            ST_PACK: begin
                // first row ends up with the highest weight
                lane_ctrl.shift = 1'b1;
                result_next     = result_reg * INDEX_W'(base_eff) + INDEX_W'(lane_sum);
                if (col_reg == order_eff - COL_ONE) begin
                    state_next = ST_OUT;
                end else begin
                    col_next = col_reg + COL_ONE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            col_reg     <= '0;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            col_reg     <= col_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        index_reg  <= index_next;
        result_reg <= result_next;
        m_data_reg <= m_data_next;
    end

    dnsg_div_chain #(
        .CELLS (MAX_ORDER)
    ) u_div_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (chain_ctrl),
        .base    (base_eff),
        .digit   (digit)
    );

    dnsg_row_lanes #(
        .ROWS       (MAX_ORDER),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_row_lanes (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .base    (base_eff),
        .digit   (digit),
        .wr_en   (load_ok),
        .wr_row  (s_entry_row),
        .wr_col  (s_entry_col),
        .wr_data (DIGIT_BITS'(s_entry_digit)),
        .rd_addr (ADDR_W'(rd_col)),
        .sum_out (lane_sum)
    );

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_data_reg;

`ifndef SYNTHESIS
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");

    a_compute_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (s_action == ACT_COMPUTE)) |=> (state_reg == ST_EXT && cnt_reg == '0))
        else $error("compute item did not start digit extraction");

    a_load_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (s_action == ACT_LOAD)) |=> (state_reg == ST_IDLE))
        else $error("load item left idle");

    a_ext_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXT) |-> (cnt_reg <= EXT_LAST))
        else $error("extraction counter overran");
`endif

endmodule
